// ===== rtl/rpnh_pkg.sv =====
// ----------------------------------------------------------------------------
// rpnh_pkg: shared types and constants for the ray/polyline nearest-hit core
// Request and result structs, sequencer states, register indexes and the
// quarter-turn sine/cosine table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rpnh_pkg;

  localparam int COORD_W        = 32;
  localparam int COORD_FRAC_BITS = 16;
  localparam int TRIG_FRAC_BITS = 15;
  localparam int DIR_W          = TRIG_FRAC_BITS + 2;
  localparam int ANGLE_W        = 9;
  localparam int CFG_IDX_W      = 2;
  localparam int QUAD_STEPS     = 90;
  localparam int QUAD_IDX_W     = 7;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int DEN_W          = DIFF_W + DIR_W + 1;
  localparam int QUO_W          = DIFF_W;
  localparam int CNT_W          = 6;
  localparam int MUL_W          = 34;
  localparam int PROD_W         = 2 * MUL_W;
  localparam int TN_W           = 2 * DIFF_W + 1;
  localparam int ACC_W          = DEN_W + QUO_W;
  localparam int DIST_W         = 64;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      last_vertex;
  } vertex_req_t;

  typedef struct packed {
    logic                      hit_found;
    logic signed [COORD_W-1:0] hit_x;
    logic signed [COORD_W-1:0] hit_y;
  } hit_rsp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X  = 2'd0,
    CFG_ORIGIN_Y  = 2'd1,
    CFG_RAY_ANGLE = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEN0,
    S_DEN1,
    S_SN0,
    S_SN1,
    S_TN0,
    S_TN1,
    S_TN2,
    S_CHK,
    S_MX0,
    S_MX1,
    S_MX2,
    S_DIV,
    S_SQ0,
    S_SQ1,
    S_SQ2,
    S_FIN
  } seq_state_e;

  typedef logic [31:0] trig_tbl_t [QUAD_STEPS];

  // One table entry: {cos, sin} in Q1.15 for a phase of j degrees into a quadrant
  function automatic logic [31:0] trig_entry(int unsigned j);
    longint unsigned one;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned ts;
    longint unsigned tc;
    longint unsigned v;
    longint unsigned sv;
    longint unsigned cv;
    longint unsigned s;
    longint unsigned c;
    one = 64'd1 << 30;
    r   = 64'(4 * j);
    x   = (64'd1686629713 * r) / 360;
    x2  = (x * x) >> 30;
    ts  = one;
    ts  = one - ((x2 * ts) >> 30) / 210;
    ts  = one - ((x2 * ts) >> 30) / 156;
    ts  = one - ((x2 * ts) >> 30) / 110;
    ts  = one - ((x2 * ts) >> 30) / 72;
    ts  = one - ((x2 * ts) >> 30) / 42;
    ts  = one - ((x2 * ts) >> 30) / 20;
    ts  = one - ((x2 * ts) >> 30) / 6;
    tc  = one;
    tc  = one - ((x2 * tc) >> 30) / 182;
    tc  = one - ((x2 * tc) >> 30) / 132;
    tc  = one - ((x2 * tc) >> 30) / 90;
    tc  = one - ((x2 * tc) >> 30) / 56;
    tc  = one - ((x2 * tc) >> 30) / 30;
    tc  = one - ((x2 * tc) >> 30) / 12;
    v   = ((x2 * tc) >> 30) / 2;
    cv  = (v >= one) ? 64'd0 : one - v;
    sv  = (x * ts) >> 30;
    if (sv > one) begin
      sv = one;
    end
    s = (sv + (64'd1 << (30 - TRIG_FRAC_BITS - 1))) >> (30 - TRIG_FRAC_BITS);
    c = (cv + (64'd1 << (30 - TRIG_FRAC_BITS - 1))) >> (30 - TRIG_FRAC_BITS);
    return {c[15:0], s[15:0]};
  endfunction

  function automatic trig_tbl_t build_trig_tbl();
    trig_tbl_t t;
    for (int j = 0; j < QUAD_STEPS; j++) begin
      t[j] = trig_entry(j);
    end
    return t;
  endfunction

  localparam trig_tbl_t TRIG_TBL = build_trig_tbl();

endpackage

`default_nettype wire

// ===== rtl/rpnh_div.sv =====
// ----------------------------------------------------------------------------
// rpnh_div: restoring divider, one quotient bit per cycle
// Starts with a partial remainder already below the divisor and shifts in the
// remaining numerator bits; the quotient is valid in the cycle done_o is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rpnh_div
  import rpnh_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DEN_W-1:0] rem_init_i,
  input  wire logic [QUO_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic [QUO_W-1:0]      quo_o
);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q;
  logic [QUO_W-1:0] nq_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, nq_q[QUO_W-1]};
  assign ge    = trial >= {1'b0, den_i};
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(QUO_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_init_i;
      nq_q  <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      nq_q  <= {nq_q[QUO_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = nq_q;

endmodule

`default_nettype wire

// ===== rtl/ray_polyline_nearest_hit_core.sv =====
// ----------------------------------------------------------------------------
// ray_polyline_nearest_hit_core: nearest ray hit on a streamed polyline
// Intersects each closed segment with the configured ray and reports the hit
// nearest the origin when the last vertex arrives.
// ----------------------------------------------------------------------------
// A vertex request is taken only while the core is idle. The first vertex of a
// polyline is only stored; each later vertex uses a single 34x34 multiplier
// used for every product in turn and a bit-serial divider that runs once for
// each of the two hit coordinates; a segment that misses the ray ends early,
// after the range check. A result waits in an output register, so the core
// takes later vertices while it is pending, holding only a last vertex back.
`timescale 1ns / 1ps
`default_nettype none

module ray_polyline_nearest_hit_core
  import rpnh_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COORD_W-1:0]   cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire vertex_req_t          in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output hit_rsp_t                  out_data_o
);

  seq_state_e state_q, state_d;

  logic signed [COORD_W-1:0] origin_x_q, origin_y_q;
  logic [ANGLE_W-1:0]        ray_angle_q;

  logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
  logic                      have_prev_q;
  logic                      best_found_q;
  logic [DIST_W-1:0]         best_dist_q;
  logic signed [COORD_W-1:0] best_x_q, best_y_q;

  logic signed [COORD_W-1:0] vx_q, vy_q;
  logic                      last_q;
  logic signed [DIR_W-1:0]   ddx_q, ddy_q;
  logic signed [DIFF_W-1:0]  ex_q, ey_q, wx_q, wy_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [TN_W-1:0]    t0_q;
  logic signed [DEN_W-1:0]   den_q, sn_q;
  logic                      seg_ok_q;
  logic [ACC_W-1:0]          acc_q;
  logic                      axis_q;
  logic signed [COORD_W-1:0] hx_q, hy_q;

  logic     out_valid_q;
  hit_rsp_t out_q;

  logic in_accept;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q  <= '0;
      origin_y_q  <= '0;
      ray_angle_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:  origin_x_q  <= cfg_data_i;
        CFG_ORIGIN_Y:  origin_y_q  <= cfg_data_i;
        CFG_RAY_ANGLE: ray_angle_q <= cfg_data_i[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Direction from the quarter-turn table
  logic [ANGLE_W-1:0]        deg;
  logic [ANGLE_W-1:0]        deg_rem;
  logic [1:0]                quad;
  logic [31:0]               trig_word;
  logic signed [DIR_W-1:0]   cos_v, sin_v, dir_x, dir_y;

  always_comb begin
    deg = (ray_angle_q >= ANGLE_W'(360)) ? ray_angle_q - ANGLE_W'(360) : ray_angle_q;
    if (deg < ANGLE_W'(90)) begin
      quad    = 2'd0;
      deg_rem = deg;
    end else if (deg < ANGLE_W'(180)) begin
      quad    = 2'd1;
      deg_rem = deg - ANGLE_W'(90);
    end else if (deg < ANGLE_W'(270)) begin
      quad    = 2'd2;
      deg_rem = deg - ANGLE_W'(180);
    end else begin
      quad    = 2'd3;
      deg_rem = deg - ANGLE_W'(270);
    end
    trig_word = TRIG_TBL[deg_rem[QUAD_IDX_W-1:0]];
    cos_v     = {1'b0, trig_word[31:16]};
    sin_v     = {1'b0, trig_word[15:0]};
    case (quad)
      2'd0: begin
        dir_x = cos_v;
        dir_y = sin_v;
      end
      2'd1: begin
        dir_x = -sin_v;
        dir_y = cos_v;
      end
      2'd2: begin
        dir_x = -cos_v;
        dir_y = -sin_v;
      end
      default: begin
        dir_x = sin_v;
        dir_y = -cos_v;
      end
    endcase
  end

  // Shared multiplier operands and helpers
  logic signed [DIFF_W-1:0] e_sel;
  logic [QUO_W-1:0]         e_mag;
  logic signed [DIFF_W-1:0] offs_x, offs_y;
  logic [COORD_W-1:0]       ax, ay;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic                     div_start;
  logic                     div_done;
  logic [QUO_W-1:0]         div_quo;
  logic [ACC_W-1:0]         acc_d;
  logic signed [TN_W-1:0]   tn;
  logic                     tn_pos;
  logic                     sn_in_range;
  logic [DIST_W:0]          dist_sum;
  logic [DIST_W-1:0]        seg_dist;
  logic signed [COORD_W+1:0] hit_v;
  logic signed [COORD_W+1:0] quo_s;

  assign e_sel  = axis_q ? ey_q : ex_q;
  assign e_mag  = e_sel[DIFF_W-1] ? QUO_W'(-e_sel) : QUO_W'(e_sel);
  assign offs_x = {hx_q[COORD_W-1], hx_q} - {origin_x_q[COORD_W-1], origin_x_q};
  assign offs_y = {hy_q[COORD_W-1], hy_q} - {origin_y_q[COORD_W-1], origin_y_q};
  assign ax     = offs_x[DIFF_W-1] ? COORD_W'(-offs_x) : COORD_W'(offs_x);
  assign ay     = offs_y[DIFF_W-1] ? COORD_W'(-offs_y) : COORD_W'(offs_y);

  // Add the upper partial product one quotient width up
  assign acc_d  = acc_q + {prod_q[ACC_W-QUO_W-1:0], {QUO_W{1'b0}}};

  assign tn          = t0_q - prod_q[TN_W-1:0];
  assign tn_pos      = !tn[TN_W-1] && (tn != '0);
  assign sn_in_range = !sn_q[DEN_W-1] && ($unsigned(sn_q) <= $unsigned(den_q));

  assign dist_sum = {1'b0, t0_q[DIST_W-1:0]} + {1'b0, prod_q[DIST_W-1:0]};
  assign seg_dist = dist_sum[DIST_W] ? {DIST_W{1'b1}} : dist_sum[DIST_W-1:0];

  assign quo_s = {1'b0, div_quo};
  always_comb begin
    if (!axis_q) begin
      hit_v = {{2{prev_x_q[COORD_W-1]}}, prev_x_q} + (ex_q[DIFF_W-1] ? -quo_s : quo_s);
    end else begin
      hit_v = {{2{prev_y_q[COORD_W-1]}}, prev_y_q} + (ey_q[DIFF_W-1] ? -quo_s : quo_s);
    end
  end

  rpnh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .rem_init_i (acc_d[ACC_W-1:QUO_W]),
    .num_i      (acc_d[QUO_W-1:0]),
    .den_i      (den_q),
    .done_o     (div_done),
    .quo_o      (div_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = have_prev_q ? S_DEN0 : S_FIN;
        end
      end
      S_DEN0: state_d = S_DEN1;
      S_DEN1: state_d = S_SN0;
      S_SN0:  state_d = S_SN1;
      S_SN1:  state_d = S_TN0;
      S_TN0:  state_d = S_TN1;
      S_TN1:  state_d = S_TN2;
      S_TN2:  state_d = S_CHK;
      S_CHK:  state_d = (seg_ok_q && sn_in_range) ? S_MX0 : S_FIN;
      S_MX0:  state_d = S_MX1;
      S_MX1:  state_d = S_MX2;
      S_MX2:  state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = axis_q ? S_SQ0 : S_MX0;
        end
      end
      S_SQ0:  state_d = S_SQ1;
      S_SQ1:  state_d = S_SQ2;
      S_SQ2:  state_d = S_FIN;
      S_FIN: begin
        if (!last_q || !out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Multiplier operand select and divider start
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_q)
      S_DEN0: begin
        mul_a = MUL_W'(ddx_q);
        mul_b = MUL_W'(ey_q);
      end
      S_DEN1: begin
        mul_a = MUL_W'(ddy_q);
        mul_b = MUL_W'(ex_q);
      end
      S_SN0: begin
        mul_a = MUL_W'(wx_q);
        mul_b = MUL_W'(ddy_q);
      end
      S_SN1: begin
        mul_a = MUL_W'(wy_q);
        mul_b = MUL_W'(ddx_q);
      end
      S_TN0: begin
        mul_a = MUL_W'(wx_q);
        mul_b = MUL_W'(ey_q);
      end
      S_TN1: begin
        mul_a = MUL_W'(wy_q);
        mul_b = MUL_W'(ex_q);
      end
      S_MX0: begin
        mul_a = $signed({1'b0, sn_q[QUO_W-1:0]});
        mul_b = $signed({1'b0, e_mag});
      end
      S_MX1: begin
        mul_a = $signed({{(MUL_W-DEN_W+QUO_W){1'b0}}, sn_q[DEN_W-1:QUO_W]});
        mul_b = $signed({1'b0, e_mag});
      end
      S_MX2: div_start = 1'b1;
      S_SQ0: begin
        mul_a = $signed({2'b00, ax});
        mul_b = $signed({2'b00, ax});
      end
      S_SQ1: begin
        mul_a = $signed({2'b00, ay});
        mul_b = $signed({2'b00, ay});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_accept) begin
      vx_q   <= in_data_i.vertex_x;
      vy_q   <= in_data_i.vertex_y;
      last_q <= in_data_i.last_vertex;
      ddx_q  <= dir_x;
      ddy_q  <= dir_y;
      ex_q   <= {in_data_i.vertex_x[COORD_W-1], in_data_i.vertex_x}
                - {prev_x_q[COORD_W-1], prev_x_q};
      ey_q   <= {in_data_i.vertex_y[COORD_W-1], in_data_i.vertex_y}
                - {prev_y_q[COORD_W-1], prev_y_q};
      wx_q   <= {prev_x_q[COORD_W-1], prev_x_q} - {origin_x_q[COORD_W-1], origin_x_q};
      wy_q   <= {prev_y_q[COORD_W-1], prev_y_q} - {origin_y_q[COORD_W-1], origin_y_q};
      axis_q <= 1'b0;
    end
    case (state_q)
      S_DEN1: t0_q <= prod_q[TN_W-1:0];
      S_SN0:  den_q <= t0_q[DEN_W-1:0] - prod_q[DEN_W-1:0];
      S_SN1:  t0_q <= prod_q[TN_W-1:0];
      S_TN0:  sn_q <= t0_q[DEN_W-1:0] - prod_q[DEN_W-1:0];
      S_TN1:  t0_q <= prod_q[TN_W-1:0];
      S_TN2: begin
        // Normalise to a positive denominator
        seg_ok_q <= (den_q != '0) && (den_q[DEN_W-1] ? !tn_pos : !tn[TN_W-1]);
        if (den_q[DEN_W-1]) begin
          den_q <= -den_q;
          sn_q  <= -sn_q;
        end
      end
      S_MX1: acc_q <= {{(ACC_W-2*QUO_W){1'b0}}, prod_q[2*QUO_W-1:0]}
                      + {{(ACC_W-DEN_W+1){1'b0}}, den_q[DEN_W-1:1]};
      S_MX2: acc_q <= acc_d;
      S_DIV: begin
        if (div_done) begin
          if (!axis_q) begin
            hx_q <= hit_v[COORD_W-1:0];
          end else begin
            hy_q <= hit_v[COORD_W-1:0];
          end
          axis_q <= 1'b1;
        end
      end
      S_SQ1: t0_q <= prod_q[TN_W-1:0];
      default: ;
    endcase
  end

  // Polyline state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      have_prev_q  <= 1'b0;
      best_found_q <= 1'b0;
      best_dist_q  <= '1;
      best_x_q     <= '0;
      best_y_q     <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      if ((state_q == S_FIN) && last_q && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_SQ2) begin
        if (!best_found_q || (seg_dist < best_dist_q)) begin
          best_found_q <= 1'b1;
          best_dist_q  <= seg_dist;
          best_x_q     <= hx_q;
          best_y_q     <= hy_q;
        end
      end
      if (state_q == S_FIN) begin
        if (!last_q) begin
          prev_x_q    <= vx_q;
          prev_y_q    <= vy_q;
          have_prev_q <= 1'b1;
        end else if (!out_valid_q || !out_stall_i) begin
          // Emit and drop the polyline
          out_q.hit_found <= best_found_q;
          out_q.hit_x     <= best_found_q ? best_x_q : '0;
          out_q.hit_y     <= best_found_q ? best_y_q : '0;
          prev_x_q        <= '0;
          prev_y_q        <= '0;
          have_prev_q     <= 1'b0;
          best_found_q    <= 1'b0;
          best_dist_q     <= '1;
          best_x_q        <= '0;
          best_y_q        <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
